@@ hw/rtl/ptme_pkg.sv @@
// Shared types, codes and constants of the page table map engine.
`timescale 1ns / 1ps
`default_nettype none

package ptme_pkg;

   // Default sizes of the table store.
   localparam int POOL_TABLES_DEF    = 16;
   localparam int IDENTITY_HUGE_DEF  = 256;

   // Fixed geometry of one table.
   localparam int ENTRY_IDX_W = 9;
   localparam int SWEEP_W     = 11;
   localparam logic [SWEEP_W-1:0] INIT_SWEEP_LAST = 11'd1535;

   // Entry bits.
   localparam logic [63:0] BIT_PRESENT  = 64'h1;
   localparam logic [63:0] BIT_WRITABLE = 64'h2;
   localparam logic [63:0] BIT_HUGE     = 64'h80;

   // Operation codes.
   localparam logic [1:0] OP_INIT = 2'd0;
   localparam logic [1:0] OP_MAP  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   // Status codes.
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_EMPTY_L3  = 3'd1;
   localparam logic [2:0] ST_HUGE_L3   = 3'd2;
   localparam logic [2:0] ST_EMPTY_L2  = 3'd3;
   localparam logic [2:0] ST_HUGE_L2   = 3'd4;
   localparam logic [2:0] ST_EMPTY_L1  = 3'd5;
   localparam logic [2:0] ST_BAD_TABLE = 3'd6;

   // Walk levels, counted from the top table.
   localparam logic [1:0] LVL_TOP  = 2'd0;
   localparam logic [1:0] LVL_PTR  = 2'd1;
   localparam logic [1:0] LVL_DIR  = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [47:0] virt_addr;
      logic [51:0] phys_addr;
      logic [63:0] page_flags;
      logic [4:0]  table_number;
      logic [8:0]  entry_index;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] entry_value;
      logic [4:0]  tables_used;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INIT_SWEEP,
      S_WALK_RD,
      S_WALK_EVAL,
      S_ALLOC_CLR,
      S_LEAF_WR,
      S_READ_RD,
      S_READ_DATA,
      S_RESP
   } state_type;

   // Which result the datapath latches.
   typedef enum logic [1:0] {
      RES_NONE,
      RES_LEAF,
      RES_READ,
      RES_ERR
   } res_sel_type;

   typedef struct packed {
      logic        accept;
      logic        init_start;
      logic        sweep_step;
      logic        walk_rd;
      logic        alloc;
      logic        follow;
      logic        lvl_adv;
      logic        leaf_wr;
      logic        read_rd;
      logic        set_res;
      res_sel_type res_sel;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic eval_fail;
      logic eval_present;
      logic lvl_last;
      logic sweep_last;
      logic tbl_bad;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

@@ hw/rtl/ptme_ctrl.sv @@
// Controller state machine of the page table map engine.
`timescale 1ns / 1ps
`default_nettype none

module ptme_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [1:0]        req_op,
   output logic                   req_stall,
   input  wire ptme_pkg::stat_type stat,
   output ptme_pkg::cmd_type      cmd
);

   ptme_pkg::state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptme_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ptme_pkg::S_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptme_pkg::S_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  ptme_pkg::OP_INIT: state_in = ptme_pkg::S_INIT_SWEEP;
                  ptme_pkg::OP_MAP:  state_in = ptme_pkg::S_WALK_RD;
                  ptme_pkg::OP_READ: state_in = ptme_pkg::S_READ_RD;
                  default:           state_in = ptme_pkg::S_RESP;
               endcase
            end
         end
         ptme_pkg::S_INIT_SWEEP: begin
            if (stat.sweep_last) state_in = ptme_pkg::S_RESP;
         end
         ptme_pkg::S_WALK_RD: state_in = ptme_pkg::S_WALK_EVAL;
         ptme_pkg::S_WALK_EVAL: begin
            if (stat.eval_fail) begin
               state_in = ptme_pkg::S_RESP;
            end else if (stat.eval_present) begin
               state_in = stat.lvl_last ? ptme_pkg::S_LEAF_WR : ptme_pkg::S_WALK_RD;
            end else begin
               state_in = ptme_pkg::S_ALLOC_CLR;
            end
         end
         ptme_pkg::S_ALLOC_CLR: begin
            if (stat.sweep_last) begin
               state_in = stat.lvl_last ? ptme_pkg::S_LEAF_WR : ptme_pkg::S_WALK_RD;
            end
         end
         ptme_pkg::S_LEAF_WR: state_in = ptme_pkg::S_RESP;
         ptme_pkg::S_READ_RD: begin
            state_in = stat.tbl_bad ? ptme_pkg::S_RESP : ptme_pkg::S_READ_DATA;
         end
         ptme_pkg::S_READ_DATA: state_in = ptme_pkg::S_RESP;
         ptme_pkg::S_RESP: begin
            if (stat.out_free) state_in = ptme_pkg::S_IDLE;
         end
         default: state_in = ptme_pkg::S_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd = '0;
      cmd.res_sel = ptme_pkg::RES_NONE;
      case (state_ff)
         ptme_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_op == ptme_pkg::OP_INIT) begin
                  cmd.init_start = 1'b1;
               end else if (req_op != ptme_pkg::OP_MAP && req_op != ptme_pkg::OP_READ) begin
                  cmd.set_res = 1'b1;
               end
            end
         end
         ptme_pkg::S_INIT_SWEEP: begin
            cmd.sweep_step = 1'b1;
            cmd.set_res    = stat.sweep_last;
         end
         ptme_pkg::S_WALK_RD: cmd.walk_rd = 1'b1;
         ptme_pkg::S_WALK_EVAL: begin
            if (stat.eval_fail) begin
               cmd.set_res = 1'b1;
               cmd.res_sel = ptme_pkg::RES_ERR;
            end else if (stat.eval_present) begin
               cmd.follow = 1'b1;
            end else begin
               cmd.alloc = 1'b1;
            end
         end
         ptme_pkg::S_ALLOC_CLR: begin
            cmd.sweep_step = 1'b1;
            cmd.lvl_adv    = stat.sweep_last;
         end
         ptme_pkg::S_LEAF_WR: begin
            cmd.leaf_wr = 1'b1;
            cmd.set_res = 1'b1;
            cmd.res_sel = ptme_pkg::RES_LEAF;
         end
         ptme_pkg::S_READ_RD: begin
            cmd.read_rd = 1'b1;
            if (stat.tbl_bad) begin
               cmd.set_res = 1'b1;
               cmd.res_sel = ptme_pkg::RES_ERR;
            end
         end
         ptme_pkg::S_READ_DATA: begin
            cmd.set_res = 1'b1;
            cmd.res_sel = ptme_pkg::RES_READ;
         end
         ptme_pkg::S_RESP: cmd.out_load = stat.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

@@ hw/rtl/ptme_dpath.sv @@
// Datapath of the page table map engine: table memory, walk registers and result.
`timescale 1ns / 1ps
`default_nettype none

module ptme_dpath #(
   parameter int POOL_TABLES           = ptme_pkg::POOL_TABLES_DEF,
   parameter int IDENTITY_HUGE_ENTRIES = ptme_pkg::IDENTITY_HUGE_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ptme_pkg::req_payload_type req_payload,
   input  wire logic                     csr_wr_en,
   input  wire logic [51:0]              csr_wr_data,
   input  wire ptme_pkg::cmd_type        cmd,
   output ptme_pkg::stat_type            stat,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output ptme_pkg::rsp_payload_type     rsp_payload
);

   localparam int NUM_TABLES = 3 + POOL_TABLES;
   localparam int TBL_W      = $clog2(NUM_TABLES);
   localparam int ADDR_W     = TBL_W + ptme_pkg::ENTRY_IDX_W;
   localparam int DEPTH      = NUM_TABLES * 512;
   localparam int PC_W       = $clog2(POOL_TABLES + 1);

   logic [63:0] mem [DEPTH];

   logic [51:0]                  base_ff;
   ptme_pkg::req_payload_type    req_ff;
   logic [PC_W-1:0]              pool_ff, pool_in;
   logic [TBL_W-1:0]             cur_ff, cur_in;
   logic [1:0]                   lvl_ff, lvl_in;
   logic [ptme_pkg::SWEEP_W-1:0] cnt_ff, cnt_in;
   logic                         init_mode_ff, init_mode_in;
   logic [63:0]                  rdata_ff;
   logic [2:0]                   res_status_ff, res_status_in;
   logic [63:0]                  res_value_ff, res_value_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   ptme_pkg::rsp_payload_type    rsp_ff;

   logic [8:0]       walk_idx;
   logic [39:0]      link_off;
   logic             link_bad;
   logic             pool_full;
   logic [TBL_W-1:0] new_tbl;
   logic [39:0]      new_page;
   logic [63:0]      link_value;
   logic [63:0]      leaf_value;
   logic [63:0]      sweep_value;
   logic [8:0]       sweep_k;
   logic [1:0]       sweep_t;
   logic [TBL_W-1:0] rd_tbl;
   logic             huge_hit;
   logic [2:0]       eval_code;
   logic             wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [63:0]      wr_data;
   logic             rd_en;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else if (csr_wr_en) begin
         base_ff <= csr_wr_data;
      end
   end

   // Request capture on transfer.
   always_ff @(posedge clock) begin
      if (cmd.accept) req_ff <= req_payload;
   end

   // Index of the current walk level.
   always_comb begin
      case (lvl_ff)
         ptme_pkg::LVL_TOP: walk_idx = req_ff.virt_addr[47:39];
         ptme_pkg::LVL_PTR: walk_idx = req_ff.virt_addr[38:30];
         default:           walk_idx = req_ff.virt_addr[29:21];
      endcase
   end

   // Link decode of the entry just read, and allocation of a pool table.
   assign link_off   = rdata_ff[51:12] - base_ff[51:12];
   assign link_bad   = (link_off >= 40'(NUM_TABLES));
   assign pool_full  = (32'(pool_ff) >= POOL_TABLES);
   assign new_tbl    = TBL_W'(32'(pool_ff) + 32'd3);
   assign new_page   = base_ff[51:12] + 40'(new_tbl);
   assign link_value = {12'h000, new_page, 12'h000} | ptme_pkg::BIT_PRESENT
                       | ptme_pkg::BIT_WRITABLE;
   assign leaf_value = {12'h000, req_ff.phys_addr[51:12], 12'h000}
                       | ((req_ff.page_flags | ptme_pkg::BIT_PRESENT) & ~ptme_pkg::BIT_HUGE);

   // Outcome of one walk step.
   assign huge_hit = (lvl_ff != ptme_pkg::LVL_TOP) && rdata_ff[7];
   always_comb begin
      eval_code = ptme_pkg::ST_OK;
      if (rdata_ff[0]) begin
         if (huge_hit) begin
            eval_code = (lvl_ff == ptme_pkg::LVL_PTR) ? ptme_pkg::ST_HUGE_L3
                                                      : ptme_pkg::ST_HUGE_L2;
         end else if (link_bad) begin
            eval_code = ptme_pkg::ST_BAD_TABLE;
         end
      end else if (pool_full) begin
         case (lvl_ff)
            ptme_pkg::LVL_TOP: eval_code = ptme_pkg::ST_EMPTY_L3;
            ptme_pkg::LVL_PTR: eval_code = ptme_pkg::ST_EMPTY_L2;
            default:           eval_code = ptme_pkg::ST_EMPTY_L1;
         endcase
      end
   end

   // Values written by the clearing sweeps.
   assign sweep_k = cnt_ff[8:0];
   assign sweep_t = cnt_ff[10:9];
   always_comb begin
      sweep_value = '0;
      if (init_mode_ff) begin
         if (sweep_t == 2'd0 && sweep_k == 9'd0) begin
            sweep_value = {12'h000, base_ff[51:12] + 40'd1, 12'h000}
                          | ptme_pkg::BIT_PRESENT | ptme_pkg::BIT_WRITABLE;
         end else if (sweep_t == 2'd1 && sweep_k == 9'd0) begin
            sweep_value = {12'h000, base_ff[51:12] + 40'd2, 12'h000}
                          | ptme_pkg::BIT_PRESENT | ptme_pkg::BIT_WRITABLE;
         end else if (sweep_t == 2'd2 && 32'(sweep_k) < IDENTITY_HUGE_ENTRIES) begin
            sweep_value = {34'h0, sweep_k, 21'h0} | ptme_pkg::BIT_PRESENT
                          | ptme_pkg::BIT_WRITABLE | ptme_pkg::BIT_HUGE;
         end
      end
   end

   // Memory write port selection.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {cur_ff, walk_idx};
      wr_data = sweep_value;
      if (cmd.sweep_step) begin
         wr_en   = 1'b1;
         wr_addr = init_mode_ff ? {TBL_W'(sweep_t), sweep_k} : {cur_ff, sweep_k};
      end else if (cmd.alloc) begin
         wr_en   = 1'b1;
         wr_data = link_value;
      end else if (cmd.leaf_wr) begin
         wr_en   = 1'b1;
         wr_addr = {cur_ff, req_ff.virt_addr[20:12]};
         wr_data = leaf_value;
      end
   end

   // Memory read port selection; a table number past the store is not read.
   assign rd_tbl  = TBL_W'(req_ff.table_number);
   assign rd_en   = cmd.walk_rd || (cmd.read_rd && !stat.tbl_bad);
   assign rd_addr = cmd.read_rd ? {rd_tbl, req_ff.entry_index} : {cur_ff, walk_idx};

   // Table memory.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rdata_ff <= mem[rd_addr];
   end

   // Walk and sweep registers.
   always_comb begin
      pool_in      = pool_ff;
      cur_in       = cur_ff;
      lvl_in       = lvl_ff;
      cnt_in       = cnt_ff;
      init_mode_in = init_mode_ff;
      if (cmd.accept) begin
         cur_in = '0;
         lvl_in = ptme_pkg::LVL_TOP;
         cnt_in = '0;
      end
      if (cmd.init_start) begin
         pool_in      = '0;
         init_mode_in = 1'b1;
      end
      if (cmd.sweep_step) cnt_in = cnt_ff + 1'b1;
      if (cmd.alloc) begin
         pool_in      = pool_ff + 1'b1;
         cur_in       = new_tbl;
         cnt_in       = '0;
         init_mode_in = 1'b0;
      end
      if (cmd.follow) begin
         cur_in = rdata_ff[TBL_W+11:12] - base_ff[TBL_W+11:12];
         lvl_in = lvl_ff + 1'b1;
      end
      if (cmd.lvl_adv) lvl_in = lvl_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff      <= '0;
         cur_ff       <= '0;
         lvl_ff       <= ptme_pkg::LVL_TOP;
         cnt_ff       <= '0;
         init_mode_ff <= 1'b0;
      end else begin
         pool_ff      <= pool_in;
         cur_ff       <= cur_in;
         lvl_ff       <= lvl_in;
         cnt_ff       <= cnt_in;
         init_mode_ff <= init_mode_in;
      end
   end

   // Pending result.
   always_comb begin
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      if (cmd.set_res) begin
         case (cmd.res_sel)
            ptme_pkg::RES_LEAF: begin
               res_status_in = ptme_pkg::ST_OK;
               res_value_in  = leaf_value;
            end
            ptme_pkg::RES_READ: begin
               res_status_in = ptme_pkg::ST_OK;
               res_value_in  = rdata_ff;
            end
            ptme_pkg::RES_ERR: begin
               res_status_in = cmd.read_rd ? ptme_pkg::ST_BAD_TABLE : eval_code;
               res_value_in  = '0;
            end
            default: begin
               res_status_in = ptme_pkg::ST_OK;
               res_value_in  = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
   end

   // Output register; it is loaded when empty or when its transfer completes.
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (!rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.out_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.status      <= res_status_ff;
         rsp_ff.entry_value <= res_value_ff;
         rsp_ff.tables_used <= 5'(32'(pool_ff));
      end
   end

   // Status to the controller.
   assign stat.eval_present = rdata_ff[0];
   assign stat.eval_fail    = (eval_code != ptme_pkg::ST_OK);
   assign stat.lvl_last     = (lvl_ff == ptme_pkg::LVL_DIR);
   assign stat.sweep_last   = init_mode_ff ? (cnt_ff == ptme_pkg::INIT_SWEEP_LAST)
                                           : (sweep_k == 9'h1FF);
   assign stat.tbl_bad      = (32'(req_ff.table_number) >= NUM_TABLES);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

@@ hw/rtl/page_table_map_engine_top.sv @@
// Top level of the page table map engine.
`timescale 1ns / 1ps
`default_nettype none

// Four-level page-table store of (3 + POOL_TABLES) tables of 512 64-bit entries in
// one single-port-write, registered-read memory, tables placed from csr_wr_data.
// One request is worked at a time. Init sweeps the three fixed tables, one entry a
// cycle. Map is accepted, reads and evaluates the entry of each level in turn,
// writes the leaf and loads its result, or stops with an error status; each pool
// table allocated adds a clearing sweep of its 512 entries. Read reads one entry; a
// table number past the store is not read and ends with a bad table status. The
// table memory has no reset; entries never written read as undefined. A finished
// result waits in the output register.
module page_table_map_engine_top #(
   parameter int POOL_TABLES           = ptme_pkg::POOL_TABLES_DEF,
   parameter int IDENTITY_HUGE_ENTRIES = ptme_pkg::IDENTITY_HUGE_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire ptme_pkg::req_payload_type req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output ptme_pkg::rsp_payload_type     rsp_payload,
   input  wire logic                     csr_wr_en,
   input  wire logic [51:0]              csr_wr_data
);

   ptme_pkg::cmd_type  cmd;
   ptme_pkg::stat_type stat;

   // Sequencer.
   ptme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_payload.operation),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Table memory and walk datapath.
   ptme_dpath #(
      .POOL_TABLES           (POOL_TABLES),
      .IDENTITY_HUGE_ENTRIES (IDENTITY_HUGE_ENTRIES)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
